/* hdl/mexp_pkg.sv */
// ============================================================================
// mexp_pkg
// Shared types and constants of the modular exponentiation unit.
// ============================================================================
package mexp_pkg;

  // Default operand width of the arithmetic.
  localparam int unsigned DATA_BITS_DEF = 64;

  // Fixed field widths on the ports.
  localparam int unsigned WORD_W = 64;   // message word
  localparam int unsigned MOD_W  = 63;   // modulus register, result word
  localparam int unsigned EXP_W  = 64;   // exponent register
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 4;

  // Register select, taken from paddr bit 3 (8-byte spacing).
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  localparam logic [MOD_W-1:0] MODULUS_RST  = MOD_W'(2);
  localparam logic [EXP_W-1:0] EXPONENT_RST = EXP_W'(1);

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } mexp_eng_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_REDUCE,
    SEQ_CHECK,
    SEQ_MUL,
    SEQ_SQR,
    SEQ_DONE
  } mexp_seq_state_e;

  // Result hand-over from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic last;
  } mexp_res_ctl_t;

endpackage

/* hdl/modular_exponentiation_unit.sv */
// ============================================================================
// modular_exponentiation_unit
// Single-word modular exponentiation, word^exponent mod modulus.
// ============================================================================
// Each request on the input stream is one message word; the block returns
// word^exponent mod modulus, fully reduced, with tlast copied across. The
// word is first reduced modulo the modulus, then raised by right-to-left
// square-and-multiply. All products run on one shared shift-and-add modular
// multiplier, one multiplier bit a cycle. With a non-zero exponent e a word
// runs through the reduction, popcount(e) multiplies and bitlength(e)-1
// squarings, then a check and a hand-over, before the block can take the
// next request; the final squaring is skipped. With exponent zero only the
// reduction runs, and a modulus below two skips the multiplier; a full
// output register adds its wait. A modulus below two gives zero, an
// exponent of zero gives one. One request is worked on at a time; the input
// is not ready meanwhile, but a new request is taken while the previous
// result waits in the output register. Modulus (byte address 0) and exponent
// (byte address 8) are to be written over the APB port only while the block
// is idle; the block itself does not enforce this. Only the low DATA_BITS-1
// modulus bits and low DATA_BITS exponent and word bits count.
// ============================================================================
module modular_exponentiation_unit #(
  parameter int unsigned DATA_BITS = mexp_pkg::DATA_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mexp_pkg::WORD_W-1:0]   s_axis_tdata,   // [63:0] message_word
  input  logic                          s_axis_tlast,   // last_in_message
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // [62:0] result_word, [63] zero
  output logic                          m_axis_tlast,   // last_out
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mexp_pkg::APB_AW-1:0]   paddr,
  input  logic [mexp_pkg::APB_DW-1:0]   pwdata,
  output logic [mexp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mexp_pkg::*;

  logic [MOD_W-1:0]     modulus_q;
  logic [EXP_W-1:0]     exponent_q;
  logic                 cfg_wr;

  logic [DATA_BITS-1:0] mod_eff, exp_eff, word_eff, seq_word;
  mexp_res_ctl_t        seq_ctl;
  logic                 out_free, out_take;

  logic                 out_valid_q;
  logic [MOD_W-1:0]     out_word_q;
  logic                 out_last_q;

  // --- configuration registers -------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST;
      exponent_q <= EXPONENT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_MODULUS:  modulus_q  <= pwdata[MOD_W-1:0];
        REG_EXPONENT: exponent_q <= pwdata[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_MODULUS:  prdata = APB_DW'(modulus_q);
      REG_EXPONENT: prdata = APB_DW'(exponent_q);
      default:      prdata = '0;
    endcase
  end

  // Operands cut to the datapath width; modulus stays below 2^(DATA_BITS-1)
  // so a doubled residue still fits.
  assign mod_eff  = {1'b0, modulus_q[DATA_BITS-2:0]};
  assign exp_eff  = exponent_q[DATA_BITS-1:0];
  assign word_eff = s_axis_tdata[DATA_BITS-1:0];

  // --- sequencer and shared multiplier -------------------------------------
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_take = seq_ctl.valid && out_free;

  mexp_seq #(
    .DATA_BITS(DATA_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .word_i     (word_eff),
    .last_i     (s_axis_tlast),
    .mod_i      (mod_eff),
    .exp_i      (exp_eff),
    .res_ctl_o  (seq_ctl),
    .res_ready_i(out_free),
    .res_word_o (seq_word)
  );

  // --- output register -----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_word_q <= MOD_W'(seq_word);
      out_last_q <= seq_ctl.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_word_q};
  assign m_axis_tlast  = out_last_q;

  // --- assertions ----------------------------------------------------------
  // results are fully reduced
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (mod_eff >= DATA_BITS'(2)) |-> out_word_q < MOD_W'(mod_eff))
    else $error("result not below modulus");

  // degenerate modulus gives zero
  a_zero_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (mod_eff < DATA_BITS'(2)) |-> out_word_q == '0)
    else $error("non-zero result for modulus below two");

  // one word in flight in the sequencer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a word is in progress");

endmodule

/* hdl/mexp_mulmod.sv */
// ============================================================================
// mexp_mulmod
// Shared modular multiplier: interleaved shift-and-add, one multiplier bit a
// cycle, most significant first.
// ============================================================================
module mexp_mulmod #(
  parameter int unsigned DATA_BITS = mexp_pkg::DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DATA_BITS-1:0] a_i,     // multiplier, any value
  input  logic [DATA_BITS-1:0] b_i,     // multiplicand, below m
  input  logic [DATA_BITS-1:0] m_i,     // modulus, 2 .. 2^(DATA_BITS-1)-1
  output logic                 done_o,
  output logic [DATA_BITS-1:0] res_o
);
  import mexp_pkg::*;

  localparam int unsigned EW    = DATA_BITS + 2;
  localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

  mexp_eng_state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [DATA_BITS-1:0] a_q, acc_q;
  // Step addends: b, b-m, b-2m when the bit is set, else 0, -m, -2m.
  logic [EW-1:0]        b_q, bm1_q, bm2_q, nm1_q, nm2_q;

  logic [EW-1:0] two_acc, s0, s1, s2;
  logic [DATA_BITS-1:0] acc_nxt;
  logic bit_c;

  // 2*acc + bit*b lies below 3m; keep the largest multiple of m that fits.
  always_comb begin
    bit_c   = a_q[DATA_BITS-1];
    two_acc = {1'b0, acc_q, 1'b0};
    s0      = two_acc + (bit_c ? b_q   : '0);
    s1      = two_acc + (bit_c ? bm1_q : nm1_q);
    s2      = two_acc + (bit_c ? bm2_q : nm2_q);
    if (!s2[EW-1]) begin
      acc_nxt = s2[DATA_BITS-1:0];
    end else if (!s1[EW-1]) begin
      acc_nxt = s1[DATA_BITS-1:0];
    end else begin
      acc_nxt = s0[DATA_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: begin
        if (start_i) state_d = ENG_RUN;
      end
      ENG_RUN: begin
        if (cnt_q == CNT_W'(1)) state_d = ENG_IDLE;
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ENG_RUN) && (cnt_q == CNT_W'(1));
      if (state_q == ENG_IDLE && start_i) begin
        cnt_q <= CNT_W'(DATA_BITS);
      end else if (state_q == ENG_RUN) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ENG_IDLE && start_i) begin
      a_q   <= a_i;
      acc_q <= '0;
      b_q   <= {2'b00, b_i};
      bm1_q <= {2'b00, b_i} - {2'b00, m_i};
      bm2_q <= {2'b00, b_i} - {1'b0, m_i, 1'b0};
      nm1_q <= EW'(0) - {2'b00, m_i};
      nm2_q <= EW'(0) - {1'b0, m_i, 1'b0};
    end else if (state_q == ENG_RUN) begin
      a_q   <= {a_q[DATA_BITS-2:0], 1'b0};
      acc_q <= acc_nxt;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* hdl/mexp_seq.sv */
// ============================================================================
// mexp_seq
// Square-and-multiply sequencer around the shared modular multiplier.
// ============================================================================
module mexp_seq #(
  parameter int unsigned DATA_BITS = mexp_pkg::DATA_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DATA_BITS-1:0]    word_i,
  input  logic                    last_i,
  input  logic [DATA_BITS-1:0]    mod_i,
  input  logic [DATA_BITS-1:0]    exp_i,
  output mexp_pkg::mexp_res_ctl_t res_ctl_o,
  input  logic                    res_ready_i,
  output logic [DATA_BITS-1:0]    res_word_o
);
  import mexp_pkg::*;

  mexp_seq_state_e state_q, state_d;
  logic [DATA_BITS-1:0] m_q, e_q, base_q, acc_q;
  logic                 last_q;

  logic                 eng_start, eng_done;
  logic [DATA_BITS-1:0] eng_a, eng_b, eng_m, eng_res;
  logic ld_in, ld_base, ld_acc_one, ld_acc_res, ld_acc_zero, clr_e0, shr_e;

  mexp_mulmod #(
    .DATA_BITS(DATA_BITS)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(eng_start),
    .a_i    (eng_a),
    .b_i    (eng_b),
    .m_i    (eng_m),
    .done_o (eng_done),
    .res_o  (eng_res)
  );

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    eng_start   = 1'b0;
    eng_a       = acc_q;
    eng_b       = base_q;
    eng_m       = m_q;
    ld_in       = 1'b0;
    ld_base     = 1'b0;
    ld_acc_one  = 1'b0;
    ld_acc_res  = 1'b0;
    ld_acc_zero = 1'b0;
    clr_e0      = 1'b0;
    shr_e       = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ld_in = 1'b1;
          if (mod_i < DATA_BITS'(2)) begin
            // degenerate modulus: result is zero
            ld_acc_zero = 1'b1;
            state_d     = SEQ_DONE;
          end else begin
            // word mod m as word * 1
            eng_start = 1'b1;
            eng_a     = word_i;
            eng_b     = DATA_BITS'(1);
            eng_m     = mod_i;
            state_d   = SEQ_REDUCE;
          end
        end
      end
      SEQ_REDUCE: begin
        if (eng_done) begin
          ld_base    = 1'b1;
          ld_acc_one = 1'b1;
          state_d    = SEQ_CHECK;
        end
      end
      SEQ_CHECK: begin
        if (e_q == '0) begin
          state_d = SEQ_DONE;
        end else if (e_q[0]) begin
          eng_start = 1'b1;
          state_d   = SEQ_MUL;
        end else begin
          eng_start = 1'b1;
          eng_a     = base_q;
          state_d   = SEQ_SQR;
        end
      end
      SEQ_MUL: begin
        if (eng_done) begin
          ld_acc_res = 1'b1;
          clr_e0     = 1'b1;
          state_d    = SEQ_CHECK;
        end
      end
      SEQ_SQR: begin
        if (eng_done) begin
          ld_base = 1'b1;
          shr_e   = 1'b1;
          state_d = SEQ_CHECK;
        end
      end
      SEQ_DONE: begin
        if (res_ready_i) state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      m_q    <= mod_i;
      e_q    <= exp_i;
      last_q <= last_i;
    end else if (clr_e0) begin
      e_q[0] <= 1'b0;
    end else if (shr_e) begin
      e_q <= {1'b0, e_q[DATA_BITS-1:1]};
    end
    if (ld_base) base_q <= eng_res;
    if (ld_acc_zero) begin
      acc_q <= '0;
    end else if (ld_acc_one) begin
      acc_q <= DATA_BITS'(1);
    end else if (ld_acc_res) begin
      acc_q <= eng_res;
    end
  end

  assign res_ctl_o.valid = (state_q == SEQ_DONE);
  assign res_ctl_o.last  = last_q;
  assign res_word_o      = acc_q;

endmodule

/* tb/sv/tb_modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_modular_exponentiation_unit
// Self-checking regression of the modular exponentiation unit.
// ============================================================================
// Message words go in through the input stream from a queue of pending
// requests. Each accepted request is run through a local square-and-multiply
// predictor using the testbench's copy of modulus and exponent, and the
// expected residue is queued. Results on the output stream are checked in
// order against that queue. Modulus and exponent are reprogrammed over APB
// only once the block has drained, and read back once both are written. A short
// directed part covers the register extremes, exponent zero, a modulus below
// two and the ignored top bit of the modulus write. Random settings follow
// under three back-pressure patterns.
// ============================================================================
module tb_modular_exponentiation_unit;
  import mexp_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 9_000;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_req_t;

  typedef struct {
    logic [MOD_W-1:0] residue;
    logic             last;
  } power_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              s_axis_tvalid  = 1'b0;
  logic              s_axis_tready;
  logic [WORD_W-1:0] s_axis_tdata   = '0;  // [63:0] message_word
  logic              s_axis_tlast   = 1'b0; // last_in_message
  logic              m_axis_tvalid;
  logic              m_axis_tready  = 1'b0;
  logic [63:0]       m_axis_tdata;          // [62:0] result_word, [63] zero
  logic              m_axis_tlast;          // last_out
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [APB_AW-1:0] paddr          = '0;
  logic [APB_DW-1:0] pwdata         = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Local copy of the configuration, changed only while the block is idle.
  logic [MOD_W-1:0]  cur_modulus  = MODULUS_RST;
  logic [EXP_W-1:0]  cur_exponent = EXPONENT_RST;

  word_req_t         word_q[$];    // requests not yet presented
  power_t            power_q[$];   // expected residues, oldest first
  int unsigned       words_queued   = 0;
  int unsigned       words_accepted = 0;
  int unsigned       error_count    = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;

  modular_exponentiation_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Shift-and-add product, multiplier MSB first; a, b < m < 2^63 so the
  // doubled or summed accumulator never overflows 64 bits.
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= m) acc = acc - m;
      if (a[i]) begin
        acc = acc + b;
        if (acc >= m) acc = acc - m;
      end
    end
    return acc;
  endfunction

  // Right-to-left square-and-multiply; a modulus of 0 or 1 yields zero.
  function automatic logic [MOD_W-1:0] predict_power(logic [WORD_W-1:0] word,
                                                     logic [EXP_W-1:0] expn,
                                                     logic [MOD_W-1:0] modn);
    logic [63:0] m;
    logic [63:0] base;
    logic [63:0] acc;
    logic [63:0] e;
    if (modn < 2) return '0;
    m    = {1'b0, modn};
    base = word % m;
    acc  = 64'd1;
    e    = expn;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e    = e >> 1;
    end
    return acc[MOD_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: presents queued words, idles at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    word_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        power_q.push_back('{residue: predict_power(s_axis_tdata, cur_exponent,
                                                   cur_modulus),
                            last:    s_axis_tlast});
        words_accepted++;
      end
      // slot is free when nothing is held or the held request just went in
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          req           = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.word;
          s_axis_tlast  <= req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    power_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (power_q.size() == 0) begin
          $error("unexpected result: result_word %0h last_out %0b",
                 m_axis_tdata[MOD_W-1:0], m_axis_tlast);
          error_count++;
        end else begin
          exp_res = power_q.pop_front();
          if (m_axis_tdata[MOD_W-1:0] !== exp_res.residue) begin
            $error("result_word: expected %0h, actual %0h",
                   exp_res.residue, m_axis_tdata[MOD_W-1:0]);
            error_count++;
          end
          if (m_axis_tlast !== exp_res.last) begin
            $error("last_out: expected %0b, actual %0b",
                   exp_res.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modular_exponentiation_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic reg_sel,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    // transfer completes on the edge where pready is seen high
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic reg_sel, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, reg_sel, '0, rd);
    if (rd !== want) begin
      $error("%s: expected %0h, actual %0h",
             (reg_sel == REG_MODULUS) ? "modulus" : "exponent", want, rd);
      error_count++;
    end
  endtask

  // Block is idle once every accepted request has produced its result.
  task automatic wait_drained();
    while (words_accepted != words_queued || power_q.size() != 0)
      @(posedge clk_i);
  endtask

  // mod_wdata bit 63 is outside the register and must be dropped.
  task automatic program_setting(input logic [63:0] mod_wdata,
                                 input logic [EXP_W-1:0] exp_value);
    logic [APB_DW-1:0] rd;
    wait_drained();
    apb_access(1'b1, REG_MODULUS, mod_wdata, rd);
    cur_modulus = mod_wdata[MOD_W-1:0];
    apb_access(1'b1, REG_EXPONENT, exp_value, rd);
    cur_exponent = exp_value;
    check_reg(REG_MODULUS, {1'b0, cur_modulus});
    check_reg(REG_EXPONENT, cur_exponent);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
    word_q.push_back('{word: word, last: last});
    words_queued++;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(3, 0))
      0:       return {$urandom, $urandom};
      1:       return {$urandom, $urandom} % {1'b0, cur_modulus};
      2:       return WORD_W'($urandom_range(3, 0));
      default: return ~WORD_W'($urandom_range(3, 0));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0]      mod_w;
    logic [EXP_W-1:0] exp_w;
    int unsigned      nbits;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender gaps first, receiver stalls heavier
    send_idle_pct = 34;
    recv_idle_pct = 61;

    // reset values: modulus 2, exponent 1
    check_reg(REG_MODULUS, {1'b0, MODULUS_RST});
    check_reg(REG_EXPONENT, EXPONENT_RST);
    send_word('0, 1'b0);
    send_word(64'd1, 1'b1);
    send_word('1, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1);

    // largest modulus (bit 63 of the write ignored), exponent zero gives one
    program_setting('1, '0);
    send_word('1, 1'b1);
    send_word('0, 1'b0);

    // all-ones exponent, words around the modulus
    program_setting(64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_word('0, 1'b0);
    send_word(64'd1, 1'b0);
    send_word('1, 1'b1);
    send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

    // modulus below two: always zero
    program_setting('0, 64'd5);
    send_word(64'd7, 1'b1);
    send_word('1, 1'b0);
    program_setting(64'd1, '1);
    send_word(64'd3, 1'b0);
    send_word('1, 1'b1);

    // single top exponent bit: long run of squarings
    program_setting(64'd3, 64'h8000_0000_0000_0000);
    send_word(64'd2, 1'b0);
    send_word(64'd5, 1'b1);

    // small RSA pair, encrypt then decrypt
    program_setting(64'd3233, 64'd17);
    send_word(64'd65, 1'b1);
    program_setting(64'd3233, 64'd2753);
    send_word(64'd2790, 1'b1);

    // Random part: four settings per back-pressure pattern. The first
    // setting of each uses a full 64-bit exponent, the rest short ones to
    // keep the run length down.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        nbits        = $urandom_range(63, 2);
        mod_w        = {$urandom, $urandom} & ((64'd1 << nbits) - 1);
        mod_w[nbits-1] = 1'b1;
        if ($urandom_range(1, 0) != 0) mod_w[0] = 1'b1;
        mod_w[63]    = 1'($urandom_range(1, 0));
        exp_w        = {$urandom, $urandom};
        if (s == 0) begin
          exp_w[EXP_W-1] = 1'b1;
        end else begin
          nbits        = $urandom_range(24, 1);
          exp_w        = exp_w & ((64'd1 << nbits) - 1);
          exp_w[nbits-1] = 1'b1;
        end
        program_setting(mod_w, exp_w);
        for (int k = 0; k < 7; k++)
          send_word(random_word(), 1'($urandom_range(1, 0)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && power_q.size() == 0) begin
      $display("modular_exponentiation_unit regression: pass");
    end else begin
      $display("modular_exponentiation_unit regression: fail");
    end
    $finish;
  end

endmodule
